// File: rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg: shared types and constants for the binomial coefficient core
// Modulus, inverse exponent, reduction constant and the sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

  // field widths
  localparam int unsigned NWidth   = 20;
  localparam int unsigned KWidth   = 21;
  localparam int unsigned ModWidth = 30;
  localparam int unsigned ExpBits  = 30;
  localparam int unsigned IdxWidth = 5;

  typedef logic [ModWidth-1:0] word_t;
  typedef logic [NWidth-1:0]   nval_t;

  // prime modulus and the exponent that gives the inverse
  localparam word_t       PrimeMod  = 30'd1000000007;
  localparam word_t       InvExp    = PrimeMod - 30'd2;
  localparam logic [63:0] PrimeWide = 64'd1000000007;

  // reduction constant floor(2^60 / p)
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / PrimeWide);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACT,
    ST_FACT_WAIT,
    ST_POW_INIT,
    ST_ACC,
    ST_ACC_WAIT,
    ST_SQR,
    ST_SQR_WAIT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/bcm_modmul.sv
// ----------------------------------------------------------------------------
// bcm_modmul: pipelined modular multiplier
// Five stages: product, quotient estimate, quotient times modulus, difference
// and final correction. One word in, one word out; the pipeline never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcm_modmul (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  input  wire  bcm_pkg::word_t a_i,
  input  wire  bcm_pkg::word_t b_i,
  output logic                valid_o,
  output bcm_pkg::word_t      res_o
);
  import bcm_pkg::*;

  localparam logic [31:0] TwoP = 32'(PrimeMod) << 1;

  logic [4:0]  vld_q;
  logic [59:0] prod_q;
  logic [61:0] q2_q;
  logic [31:0] xlo2_q;
  logic [31:0] xlo3_q;
  logic [31:0] qp_q;
  logic [31:0] r_q;
  word_t       res_q;
  logic [60:0] qp_full;
  word_t       res_d;

  // valid travels alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // quotient estimate times modulus, only the low bits matter
  assign qp_full = 61'(q2_q[61:31]) * 61'(PrimeMod);

  // remainder lies below three times the modulus
  always_comb begin
    if (r_q >= TwoP) begin
      res_d = word_t'(r_q - TwoP);
    end else if (r_q >= 32'(PrimeMod)) begin
      res_d = word_t'(r_q - 32'(PrimeMod));
    end else begin
      res_d = word_t'(r_q);
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    prod_q <= 60'(a_i) * 60'(b_i);
    q2_q   <= 62'(prod_q[59:29]) * 62'(BarrettMu);
    xlo2_q <= prod_q[31:0];
    qp_q   <= qp_full[31:0];
    xlo3_q <= xlo2_q;
    r_q    <= xlo3_q - qp_q;
    res_q  <= res_d;
  end

  assign valid_o = vld_q[4];
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/binomial_coefficient_mod_prime_core.sv
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_core: C(n,k) modulo 1000000007
// Sequencer around one shared pipelined modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid_i / in_stall_o with n_value_i, k_value_i
//   output channel : out_valid_o / out_stall_i with binom_mod_o
//   A word is taken while the core is idle; in_stall_o stays high until the
//   answer has been placed in the output register.
//   Out-of-range queries (n above MAX_N, k negative, k above n) and k = 0
//   skip the multiplier and go straight to the output state ST_OUT. Otherwise the core
//   walks i = 1..n through the multiplier, then raises k! and (n-k)! to the
//   power p-2 by square-and-multiply over 30 exponent bits, folding both
//   into n!. Each multiply is issued into the shared 5-stage multiplier
//   and its result is awaited before the next step; each exponent bit also
//   passes the decision state ST_ACC; p-2 has 15 set bits. The next query
//   can be taken once the answer has been loaded. The answer waits in the
//   output register while out_stall_i is high; the next query is accepted
//   meanwhile.
//   Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_mod_prime_core #(
  parameter int unsigned MAX_N = 1048575
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [19:0]          n_value_i,
  input  wire  signed [20:0]   k_value_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [29:0]          binom_mod_o
);
  import bcm_pkg::*;

  localparam logic [23:0] MaxN = 24'(MAX_N);

  state_e              state_q, state_d;
  nval_t               n_q, n_d;
  nval_t               k_q, k_d;
  nval_t               rest_q, rest_d;
  nval_t               i_q, i_d;
  word_t               f_q, f_d;
  word_t               fk_q, fk_d;
  word_t               frest_q, frest_d;
  word_t               base_q, base_d;
  logic [IdxWidth-1:0] bit_q, bit_d;
  logic                pass_q, pass_d;
  logic                out_valid_q;
  word_t               binom_q;
  logic                out_load;
  logic                in_accept;
  logic                q_zero;
  logic                q_one;

  logic                mul_valid;
  word_t               mul_a;
  word_t               mul_b;
  logic                mul_done;
  word_t               mul_res;

  bcm_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .valid_o (mul_done),
    .res_o   (mul_res)
  );

  assign in_accept = in_valid_i && (state_q == ST_IDLE);

  // query classification
  assign q_zero = ({4'd0, n_value_i} > MaxN) || k_value_i[KWidth-1] ||
                  (k_value_i[NWidth-1:0] > n_value_i);
  assign q_one  = (k_value_i[NWidth-1:0] == '0);

  // sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    rest_d    = rest_q;
    i_d       = i_q;
    f_d       = f_q;
    fk_d      = fk_q;
    frest_d   = frest_q;
    base_d    = base_q;
    bit_d     = bit_q;
    pass_d    = pass_q;
    mul_valid = 1'b0;
    mul_a     = f_q;
    mul_b     = base_q;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_d     = n_value_i;
          k_d     = k_value_i[NWidth-1:0];
          rest_d  = n_value_i - k_value_i[NWidth-1:0];
          i_d     = nval_t'(1);
          fk_d    = word_t'(1);
          frest_d = word_t'(1);
          if (q_zero) begin
            f_d     = '0;
            state_d = ST_OUT;
          end else if (q_one) begin
            f_d     = word_t'(1);
            state_d = ST_OUT;
          end else begin
            f_d     = word_t'(1);
            state_d = ST_FACT;
          end
        end
      end
      ST_FACT: begin
        mul_valid = 1'b1;
        mul_b     = word_t'(i_q);
        state_d   = ST_FACT_WAIT;
      end
      ST_FACT_WAIT: begin
        if (mul_done) begin
          f_d = mul_res;
          if (i_q == k_q) begin
            fk_d = mul_res;
          end
          if (i_q == rest_q) begin
            frest_d = mul_res;
          end
          if (i_q == n_q) begin
            pass_d  = 1'b0;
            state_d = ST_POW_INIT;
          end else begin
            i_d     = i_q + nval_t'(1);
            state_d = ST_FACT;
          end
        end
      end
      ST_POW_INIT: begin
        base_d  = pass_q ? frest_q : fk_q;
        bit_d   = '0;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (InvExp[bit_q]) begin
          mul_valid = 1'b1;
          state_d   = ST_ACC_WAIT;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_ACC_WAIT: begin
        if (mul_done) begin
          f_d     = mul_res;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        mul_valid = 1'b1;
        mul_a     = base_q;
        state_d   = ST_SQR_WAIT;
      end
      ST_SQR_WAIT: begin
        if (mul_done) begin
          base_d = mul_res;
          if (bit_q == IdxWidth'(ExpBits - 1)) begin
            if (!pass_q) begin
              pass_d  = 1'b1;
              state_d = ST_POW_INIT;
            end else begin
              state_d = ST_OUT;
            end
          end else begin
            bit_d   = bit_q + IdxWidth'(1);
            state_d = ST_ACC;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and output word
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    k_q     <= k_d;
    rest_q  <= rest_d;
    i_q     <= i_d;
    f_q     <= f_d;
    fk_q    <= fk_d;
    frest_q <= frest_d;
    base_q  <= base_d;
    bit_q   <= bit_d;
    pass_q  <= pass_d;
    if (out_load) begin
      binom_q <= f_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign binom_mod_o = binom_q;

endmodule

`default_nettype wire

// File: rtl/bcm_checker.sv
// ----------------------------------------------------------------------------
// bcm_checker: port-level checks for the binomial coefficient core
// Watches the handshakes and result range; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcm_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input wire signed [20:0] k_value_i,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire [29:0]        binom_mod_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(binom_mod_o))
    else $error("result word changed while stalled");

  // results stay below the modulus
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> binom_mod_o < 30'd1000000007)
    else $error("result not reduced");

  // one query at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while busy");

  // negative k into a free output is answered with zero
  a_neg_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && k_value_i[20] && !out_valid_o
    |-> ##2 (out_valid_o && binom_mod_o == 30'd0))
    else $error("negative k not answered with zero");

endmodule

bind binomial_coefficient_mod_prime_core bcm_checker u_bcm_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binomial_coefficient_mod_prime_core
// Sends (n, k) queries over the valid/stall channel and predicts C(n,k) mod p
// for each accepted query. It checks every answer word, in order, against
// that prediction. Runs directed edge cases, one long factorial walk, then
// random queries under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import bcm_pkg::*;

  localparam int unsigned MaxN       = 1048575;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned LargeN     = 65535;
  localparam longint unsigned Prime  = 64'(PrimeMod);

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  nval_t              n_value_i;
  logic signed [20:0] k_value_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  word_t              binom_mod_o;

  word_t       binom_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  binomial_coefficient_mod_prime_core #(
    .MAX_N(MaxN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .n_value_i  (n_value_i),
    .k_value_i  (k_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .binom_mod_o(binom_mod_o)
  );

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall, changed on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // x^e mod p by square-and-multiply
  function automatic longint unsigned pow_mod_prime(input longint unsigned base,
                                                    input longint unsigned e);
    longint unsigned acc;
    longint unsigned b;
    longint unsigned ex;
    acc = 1;
    b   = base % Prime;
    ex  = e;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * b) % Prime;
      b  = (b * b) % Prime;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // C(n,k) mod p, zero when n or k is out of range
  function automatic word_t binom_mod_prime(input nval_t n, input logic signed [20:0] k);
    longint unsigned f;
    longint unsigned fk;
    longint unsigned frest;
    longint unsigned idx;
    longint unsigned kk;
    longint unsigned rest;
    if (n > MaxN || k[20] || k[19:0] > n) return '0;
    if (k == 0) return word_t'(1);
    kk    = k[19:0];
    rest  = n - kk;
    f     = 1;
    fk    = 1;
    frest = 1;
    for (idx = 1; idx <= n; idx++) begin
      f = (f * idx) % Prime;
      if (idx == kk) fk = f;
      if (idx == rest) frest = f;
    end
    f = (f * pow_mod_prime(fk, 64'(InvExp))) % Prime;
    f = (f * pow_mod_prime(frest, 64'(InvExp))) % Prime;
    return word_t'(f);
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatch_count++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // answer checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (binom_expected.size() == 0) begin
        report_mismatch("unexpected binom_mod word", binom_mod_o, '0);
      end else begin
        if (binom_mod_o !== binom_expected[0])
          report_mismatch("binom_mod word", binom_mod_o, binom_expected[0]);
        void'(binom_expected.pop_front());
      end
    end
  end

  // offer one query word; entered and left on a falling edge
  task automatic send_query(input nval_t n, input logic signed [20:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    n_value_i  <= n;
    k_value_i  <= k;
    do @(posedge clk_i); while (in_stall_o);
    binom_expected.push_back(binom_mod_prime(n, k));
    @(negedge clk_i);
  endtask

  // stop offering and wait for every outstanding answer
  task automatic drain_answers();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (binom_expected.size() != 0) @(negedge clk_i);
  endtask

  // bounds of n and k, negative k, k above n, k zero and tiny walks
  task automatic test_edge_cases();
    send_query(20'(MaxN), -21'sd1);
    send_query(20'(MaxN), -21'sd1048576);
    send_query(20'd0, -21'sd1);
    send_query(20'd0, 21'sd1);
    send_query(20'd5, 21'sd6);
    send_query(20'd1048574, 21'sd1048575);
    send_query(20'd0, 21'sd1048575);
    send_query(20'd0, 21'sd0);
    send_query(20'(MaxN), 21'sd0);
    send_query(20'd1, 21'sd1);
    send_query(20'd2, 21'sd1);
    send_query(20'd2, 21'sd2);
    send_query(20'd10, 21'sd5);
    send_query(20'd33, 21'sd17);
    send_query(20'd40, 21'sd39);
    send_query(20'h55555, -21'sd699051);
    send_query(20'h2aaaa, 21'sh0aaaab);
    drain_answers();
  endtask

  // one long factorial walk
  task automatic test_large_n();
    send_query(20'(LargeN), 21'(LargeN / 2 + 1));
    drain_answers();
  endtask

  // random mix: mostly real computations on small n, rest fast-path queries
  task automatic test_random(input int unsigned count);
    nval_t              n;
    logic signed [20:0] k;
    int unsigned        sel;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        n = 20'($urandom_range(1, 48));
        k = 21'($urandom_range(0, n));
      end else if (sel < 72) begin
        n = 20'($urandom);
        k = '0;
      end else if (sel < 86) begin
        n = 20'($urandom);
        k = {1'b1, 20'($urandom)};
      end else begin
        n = 20'($urandom_range(0, MaxN - 1));
        k = 21'($urandom_range(n + 1, MaxN));
      end
      send_query(n, k);
    end
  endtask

  // sender holds off until the core has answered everything
  task automatic test_drain_pause();
    test_random(6);
    drain_answers();
    test_random(6);
    drain_answers();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    n_value_i   = '0;
    k_value_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_edge_cases();
    test_large_n();
    test_random(22);
    drain_answers();

    send_idle_pct  = 79;
    recv_stall_pct = 0;
    test_random(22);
    drain_answers();

    send_idle_pct  = 0;
    recv_stall_pct = 79;
    test_random(22);
    test_drain_pause();

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    test_random(22);
    drain_answers();

    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && binom_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
